/* design/bmsf_pkg.sv */
// ----------------------------------------------------------------------------
// bmsf_pkg
// Shared types and constants of the broadcast/multicast filter.
// ----------------------------------------------------------------------------
package bmsf_pkg;

   localparam int NUM_INTERFACES = 16;
   localparam int COUNTER_BITS   = 64;

   // counter entry = interface * 8 + class * 2 + dropped
   localparam int CNT_DEPTH = NUM_INTERFACES * 8;
   localparam int CNT_IDX_W = (CNT_DEPTH > 1) ? $clog2(CNT_DEPTH) : 1;

   localparam int INTF_W  = 4;
   localparam int MAC_W   = 48;
   localparam int ETYPE_W = 16;
   localparam int LEN_W   = 16;
   localparam int CLASS_W = 3;
   localparam int VALUE_W = 64;
   localparam int MON_W   = 16;
   localparam int DROP_W  = 64;
   localparam int CSR_W   = 64;

   localparam logic [ETYPE_W-1:0] ETH_VLAN_Q  = 16'h8100;
   localparam logic [ETYPE_W-1:0] ETH_VLAN_AD = 16'h88A8;
   localparam logic [ETYPE_W-1:0] ETH_IPV4    = 16'h0800;
   localparam logic [ETYPE_W-1:0] ETH_IPV6    = 16'h86DD;

   localparam logic [MAC_W-1:0] MAC_BCAST    = 48'hFFFF_FFFF_FFFF;
   localparam logic [23:0]      MAC_IPV4_PFX = 24'h01005E;
   localparam logic [15:0]      MAC_IPV6_PFX = 16'h3333;

   localparam logic [LEN_W-1:0] LEN_MIN_FRAME = 16'd14;
   localparam logic [LEN_W-1:0] LEN_ONE_TAG   = 16'd18;
   localparam logic [LEN_W-1:0] LEN_TWO_TAGS  = 16'd22;

   typedef enum logic {
      OP_CLASSIFY = 1'b0,
      OP_READ     = 1'b1
   } op_type;

   typedef enum logic [CLASS_W-1:0] {
      CLS_BCAST = 3'd0,
      CLS_IPV4  = 3'd1,
      CLS_IPV6  = 3'd2,
      CLS_OTHER = 3'd3,
      CLS_NONE  = 3'd4
   } class_type;

   typedef enum logic {
      CSR_MONITORED  = 1'b0,
      CSR_DROP_FLAGS = 1'b1
   } csr_index_type;

   typedef struct packed {
      op_type               opcode;
      logic [INTF_W-1:0]    intf_index;
      logic [MAC_W-1:0]     dest_mac;
      logic [ETYPE_W-1:0]   outer_ethertype;
      logic [ETYPE_W-1:0]   tag1_ethertype;
      logic [ETYPE_W-1:0]   tag2_ethertype;
      logic [LEN_W-1:0]     frame_length;
      logic [1:0]           read_class;
      logic                 read_dropped;
   } req_type;

   typedef struct packed {
      logic                 is_read;
      logic                 read_ok;
      logic                 count;
      logic                 drop;
      class_type            cls;
      logic [CNT_IDX_W-1:0] idx;
   } class_result_type;

endpackage

/* design/bmsf_req_if.sv */
// ----------------------------------------------------------------------------
// bmsf_req_if
// Request channel: frame header to classify, or a counter read.
// ----------------------------------------------------------------------------
interface bmsf_req_if import bmsf_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                opcode;
   logic [INTF_W-1:0]   intf_index;
   logic [MAC_W-1:0]    dest_mac;
   logic [ETYPE_W-1:0]  outer_ethertype;
   logic [ETYPE_W-1:0]  tag1_ethertype;
   logic [ETYPE_W-1:0]  tag2_ethertype;
   logic [LEN_W-1:0]    frame_length;
   logic [1:0]          read_class;
   logic                read_dropped;

   modport source (
      output valid, opcode, intf_index, dest_mac, outer_ethertype,
             tag1_ethertype, tag2_ethertype, frame_length, read_class, read_dropped,
      input  ready
   );
   modport sink (
      input  valid, opcode, intf_index, dest_mac, outer_ethertype,
             tag1_ethertype, tag2_ethertype, frame_length, read_class, read_dropped,
      output ready
   );
endinterface

/* design/bmsf_rsp_if.sv */
// ----------------------------------------------------------------------------
// bmsf_rsp_if
// Response channel: verdict, traffic class and counter value.
// ----------------------------------------------------------------------------
interface bmsf_rsp_if import bmsf_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                verdict;
   logic [CLASS_W-1:0]  traffic_class;
   logic [VALUE_W-1:0]  counter_value;

   modport source (
      output valid, verdict, traffic_class, counter_value,
      input  ready
   );
   modport sink (
      input  valid, verdict, traffic_class, counter_value,
      output ready
   );
endinterface

/* design/bmsf_ram.sv */
// ----------------------------------------------------------------------------
// bmsf_ram
// Generic single-write, single-read RAM with registered read data.
// A read at the address being written returns the old contents.
// ----------------------------------------------------------------------------
module bmsf_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 128
) (
   input  logic                                  clock,
   input  logic                                  we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                      wdata,
   input  logic                                  re,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                      rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* design/bmsf_classify.sv */
// ----------------------------------------------------------------------------
// bmsf_classify
// Header classification, drop decision and counter entry selection.
// ----------------------------------------------------------------------------
module bmsf_classify import bmsf_pkg::*; (
   input  req_type             req,
   input  logic [MON_W-1:0]    monitored,
   input  logic [DROP_W-1:0]   drop_flags,
   output class_result_type    res
);

   function automatic logic is_vlan_tag(input logic [ETYPE_W-1:0] et);
      return (et == ETH_VLAN_Q) || (et == ETH_VLAN_AD);
   endfunction

   logic                intf_ok;
   logic [ETYPE_W-1:0]  final_et;
   class_type           cls;
   logic                monitored_bit;
   logic                drop_bit;

   assign intf_ok = 32'(req.intf_index) < NUM_INTERFACES;

   // skip up to two tags, each only if the captured length covers it
   always_comb begin
      if (!is_vlan_tag(req.outer_ethertype) || req.frame_length < LEN_ONE_TAG) begin
         final_et = req.outer_ethertype;
      end else if (!is_vlan_tag(req.tag1_ethertype) || req.frame_length < LEN_TWO_TAGS) begin
         final_et = req.tag1_ethertype;
      end else begin
         final_et = req.tag2_ethertype;
      end
   end

   always_comb begin
      if (req.frame_length < LEN_MIN_FRAME) begin
         cls = CLS_NONE;
      end else if (req.dest_mac == MAC_BCAST) begin
         cls = CLS_BCAST;
      end else if (req.dest_mac[40]) begin
         if (req.dest_mac[47:24] == MAC_IPV4_PFX && final_et == ETH_IPV4) begin
            cls = CLS_IPV4;
         end else if (req.dest_mac[47:32] == MAC_IPV6_PFX && final_et == ETH_IPV6) begin
            cls = CLS_IPV6;
         end else begin
            cls = CLS_OTHER;
         end
      end else begin
         cls = CLS_NONE;
      end
   end

   assign monitored_bit = monitored[req.intf_index];
   assign drop_bit      = drop_flags[{req.intf_index, cls[1:0]}];

   always_comb begin
      res.is_read = (req.opcode == OP_READ);
      res.read_ok = intf_ok;
      if (req.opcode == OP_READ) begin
         res.count = 1'b0;
         res.drop  = 1'b0;
         res.cls   = CLS_NONE;
         res.idx   = CNT_IDX_W'({req.intf_index, req.read_class, req.read_dropped});
      end else begin
         res.count = intf_ok && monitored_bit && (cls != CLS_NONE);
         res.drop  = res.count && drop_bit;
         res.cls   = cls;
         res.idx   = CNT_IDX_W'({req.intf_index, cls[1:0], res.drop});
      end
   end

endmodule

/* design/broadcast_multicast_storm_filter.sv */
// ----------------------------------------------------------------------------
// broadcast_multicast_storm_filter
// Per-interface broadcast/multicast classifier, dropper and class counters.
// ----------------------------------------------------------------------------
// Takes one transaction per clock while the response side does not stall, and
// returns exactly one response per transaction, in order, from the input,
// counter RAM read and result registers in turn. A frame header is classified
// as broadcast, IPv4 multicast, IPv6 multicast, other multicast or none; on a
// monitored interface it is dropped when that class's drop flag is set and
// counted in a wrapping passed/dropped counter. A read transaction returns one
// counter. Counters live in a 128-entry RAM updated by read-modify-write (read
// in the second stage, add and write back in the third) with forwarding of the
// latest write, so back-to-back hits on one counter run at full rate. Per-entry
// valid bits make the counters read as zero after reset; no clearing pass.
// Configuration registers apply when a transaction leaves the input register.
// ----------------------------------------------------------------------------
module broadcast_multicast_storm_filter import bmsf_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   bmsf_req_if.sink           req_chan,
   bmsf_rsp_if.source         rsp_chan,
   input  logic               csr_we,
   input  logic               csr_index,
   input  logic [CSR_W-1:0]   csr_wdata
);

   logic [MON_W-1:0]         monitored_ff;
   logic [DROP_W-1:0]        drop_flags_ff;

   logic                     s1_v_ff;
   req_type                  s1_ff;
   class_result_type         cls_res;

   logic                     s2_v_ff;
   class_result_type         s2_ff;
   logic                     s2_ent_valid_ff;

   logic                     rsp_v_ff;
   logic                     out_verdict_ff;
   logic [CLASS_W-1:0]       out_class_ff;
   logic [VALUE_W-1:0]       out_value_ff;

   logic [CNT_DEPTH-1:0]     cnt_valid_ff;
   logic                     lw_v_ff;
   logic [CNT_IDX_W-1:0]     lw_idx_ff;
   logic [COUNTER_BITS-1:0]  lw_data_ff;

   logic                     en_out;
   logic                     en_s2;
   logic                     en_s1;
   logic                     ram_we;
   logic                     ram_re;
   logic [COUNTER_BITS-1:0]  ram_rdata;
   logic [COUNTER_BITS-1:0]  cur_val;
   logic [COUNTER_BITS-1:0]  next_val;
   req_type                  req_in;

   // stall chain: a stage moves when the one ahead is empty or moving
   assign en_out = !rsp_v_ff || rsp_chan.ready;
   assign en_s2  = !s2_v_ff || en_out;
   assign en_s1  = !s1_v_ff || en_s2;
   assign req_chan.ready = en_s1;

   always_comb begin
      req_in.opcode          = op_type'(req_chan.opcode);
      req_in.intf_index      = req_chan.intf_index;
      req_in.dest_mac        = req_chan.dest_mac;
      req_in.outer_ethertype = req_chan.outer_ethertype;
      req_in.tag1_ethertype  = req_chan.tag1_ethertype;
      req_in.tag2_ethertype  = req_chan.tag2_ethertype;
      req_in.frame_length    = req_chan.frame_length;
      req_in.read_class      = req_chan.read_class;
      req_in.read_dropped    = req_chan.read_dropped;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         monitored_ff  <= '0;
         drop_flags_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_MONITORED:  monitored_ff  <= csr_wdata[MON_W-1:0];
            CSR_DROP_FLAGS: drop_flags_ff <= csr_wdata[DROP_W-1:0];
            default: ;
         endcase
      end
   end

   // ---- stage 1: input register ----
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (en_s1) begin
         s1_v_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en_s1 && req_chan.valid) begin
         s1_ff <= req_in;
      end
   end

   bmsf_classify u_classify (
      .req        (s1_ff),
      .monitored  (monitored_ff),
      .drop_flags (drop_flags_ff),
      .res        (cls_res)
   );

   // ---- stage 2: counter RAM read ----
   assign ram_re = en_s2 && s1_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (en_s2) begin
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ram_re) begin
         s2_ff           <= cls_res;
         s2_ent_valid_ff <= cnt_valid_ff[cls_res.idx];
      end
   end

   bmsf_ram #(
      .WIDTH (COUNTER_BITS),
      .DEPTH (CNT_DEPTH)
   ) u_cnt_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (s2_ff.idx),
      .wdata (next_val),
      .re    (ram_re),
      .raddr (cls_res.idx),
      .rdata (ram_rdata)
   );

   // latest write wins over RAM data that may predate it
   always_comb begin
      if (lw_v_ff && lw_idx_ff == s2_ff.idx) begin
         cur_val = lw_data_ff;
      end else if (s2_ent_valid_ff) begin
         cur_val = ram_rdata;
      end else begin
         cur_val = '0;
      end
   end

   assign next_val = cur_val + COUNTER_BITS'(1);
   assign ram_we   = en_out && s2_v_ff && s2_ff.count;

   always_ff @(posedge clock) begin
      if (reset) begin
         lw_v_ff      <= 1'b0;
         cnt_valid_ff <= '0;
      end else if (ram_we) begin
         lw_v_ff                 <= 1'b1;
         cnt_valid_ff[s2_ff.idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ram_we) begin
         lw_idx_ff  <= s2_ff.idx;
         lw_data_ff <= next_val;
      end
   end

   // ---- stage 3: result register ----
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else if (en_out) begin
         rsp_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_out && s2_v_ff) begin
         out_verdict_ff <= s2_ff.drop;
         out_class_ff   <= s2_ff.cls;
         out_value_ff   <= (s2_ff.is_read && s2_ff.read_ok) ? VALUE_W'(cur_val) : '0;
      end
   end

   assign rsp_chan.valid         = rsp_v_ff;
   assign rsp_chan.verdict       = out_verdict_ff;
   assign rsp_chan.traffic_class = out_class_ff;
   assign rsp_chan.counter_value = out_value_ff;

`ifndef SYNTH
   a_write_only_counting: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> s2_v_ff && !s2_ff.is_read && s2_ff.cls != CLS_NONE)
      else $error("counter write without a counted frame");

   a_valid_after_write: assert property (@(posedge clock) disable iff (reset)
      ram_we |=> cnt_valid_ff[$past(s2_ff.idx)] && lw_idx_ff == $past(s2_ff.idx))
      else $error("counter entry not marked after write");

   a_drop_has_class: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.verdict |-> rsp_chan.traffic_class != CLS_NONE)
      else $error("drop verdict on unclassified transaction");

   a_value_only_on_read: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.counter_value != '0 |->
         rsp_chan.traffic_class == CLS_NONE && !rsp_chan.verdict)
      else $error("counter value on a classify response");

   a_stall_holds_stage2: assert property (@(posedge clock) disable iff (reset)
      s2_v_ff && !en_out |=> s2_v_ff && $stable(s2_ff))
      else $error("stage 2 changed while stalled");
`endif

endmodule
